// ----- sv/frvm_pkg.sv -----
// ----------------------------------------------------------------------------
// frvm_pkg
// Shared types and codes of the fold range visibility map.
// ----------------------------------------------------------------------------
package frvm_pkg;

  localparam int LINE_BITS      = 20;
  localparam int MAX_RANGES_DEF = 256;

  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_APPEND  = 3'd1;
  localparam logic [2:0] ACT_TOGGLE  = 3'd2;
  localparam logic [2:0] ACT_FOLD    = 3'd3;
  localparam logic [2:0] ACT_UNFOLD  = 3'd4;
  localparam logic [2:0] ACT_MAP_LN  = 3'd5;
  localparam logic [2:0] ACT_MAP_ROW = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [LINE_BITS:0]   count_t;

  typedef struct packed {
    logic [2:0] action;
    line_t      line;
    line_t      row_index;
    line_t      range_start;
    line_t      range_end;
    logic       start_collapsed;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       visible;
    line_t      visible_row;
    line_t      mapped_line;
    count_t     visible_count;
  } res_t;

  typedef struct packed {
    logic init;
    logic step;
  } qctl_t;

endpackage

// ----- sv/frvm_query.sv -----
// ----------------------------------------------------------------------------
// frvm_query
// Walk accumulator: takes merged hidden spans in order, one per step, and
// builds visibility, visible row, mapped line and visible count.
// ----------------------------------------------------------------------------
module frvm_query (
  input  logic            clk,
  input  frvm_pkg::qctl_t ctl,
  input  frvm_pkg::line_t ln,
  input  frvm_pkg::line_t row,
  input  frvm_pkg::count_t lc,
  input  frvm_pkg::line_t span_s,
  input  frvm_pkg::line_t span_e,
  output logic            vis,
  output frvm_pkg::line_t vrow,
  output frvm_pkg::line_t mline,
  output frvm_pkg::count_t vcount
);
  import frvm_pkg::*;

  localparam logic [LINE_BITS+1:0] MASK = {2'b00, {LINE_BITS{1'b1}}};

  line_t                below;
  logic                 rdone;
  count_t               hcnt;
  logic                 cdone;
  count_t               cur;
  line_t                rem;
  logic                 mdone;
  logic                 mdirect;
  line_t                mres;

  count_t               s_w, e_w, ee, span, nc;
  logic [LINE_BITS+1:0] sum, fin;

  always_comb begin
    s_w  = {1'b0, span_s};
    e_w  = {1'b0, span_e};
    ee   = (e_w >= lc) ? lc - 1'b1 : e_w;
    span = (s_w > cur) ? s_w - cur : '0;
    nc   = e_w + 1'b1;
    sum  = {1'b0, cur} + {2'b00, rem};
    fin  = sum;
    if (fin >= {1'b0, lc}) fin = {1'b0, lc} - 1'b1;
    if (fin > MASK) fin = MASK;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      vis     <= 1'b1;
      below   <= '0;
      rdone   <= 1'b0;
      hcnt    <= '0;
      cdone   <= 1'b0;
      cur     <= '0;
      rem     <= row;
      mdone   <= 1'b0;
      mdirect <= 1'b0;
    end else if (ctl.step) begin
      if (ln >= span_s && ln <= span_e) vis <= 1'b0;
      if (!rdone) begin
        if (span_s >= ln) begin
          rdone <= 1'b1;
        end else if (span_e < ln) begin
          below <= below + (span_e - span_s) + 1'b1;
        end else begin
          below <= below + (ln - span_s);
          rdone <= 1'b1;
        end
      end
      if (!cdone) begin
        if (s_w >= lc) cdone <= 1'b1;
        else hcnt <= hcnt + (ee - s_w) + 1'b1;
      end
      if (!mdone && e_w >= cur) begin
        if (s_w >= lc) begin
          mdone <= 1'b1;
        end else if ({1'b0, rem} < span) begin
          mres    <= (sum > MASK) ? MASK[LINE_BITS-1:0] : sum[LINE_BITS-1:0];
          mdone   <= 1'b1;
          mdirect <= 1'b1;
        end else begin
          rem <= rem - span[LINE_BITS-1:0];
          if (nc > lc) begin
            cur   <= lc;
            mdone <= 1'b1;
          end else begin
            cur <= nc;
          end
        end
      end
    end
  end

  assign vrow   = ln - below;
  assign vcount = lc - hcnt;
  assign mline  = mdirect ? mres : ((lc == '0) ? '0 : fin[LINE_BITS-1:0]);

endmodule

// ----- sv/fold_range_visibility_map_top.sv -----
// ----------------------------------------------------------------------------
// fold_range_visibility_map_top
// Fold range table with merged hidden span list and row mapping.
// ----------------------------------------------------------------------------
// Clear and append finish in the idle state; fold/unfold sweep every range;
// toggle seeks a range starting at the line, then one holding it; map
// queries walk the merged span list, rebuilt first after any table change.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset clears counts, stale flag and line count; tables need no clearing.
// The result is shown one cycle on done; the receiver cannot stall.
module fold_range_visibility_map_top #(
  parameter int MAX_RANGES = frvm_pkg::MAX_RANGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  frvm_pkg::cmd_t   cmd,
  output logic             done,
  output frvm_pkg::res_t   result,
  input  logic             cfg_we,
  input  frvm_pkg::count_t cfg_data
);
  import frvm_pkg::*;

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

  typedef enum logic [4:0] {
    S_IDLE, S_SWEEP, S_TG_RD, S_TG_CMP, S_FL_RD, S_FL_WR,
    S_RB_RD, S_RB_CHK, S_RB_CMP, S_RB_INS, S_MG_RD, S_MG_USE, S_MG_FLUSH,
    S_Q_INIT, S_Q_RD, S_Q_USE, S_Q_END
  } state_t;

  logic [2*LINE_BITS-1:0] fold_se [MAX_RANGES];
  logic                   fold_col [MAX_RANGES];
  logic [2*LINE_BITS-1:0] hid [MAX_RANGES];

  state_t                 state;
  cmd_t                   cq;
  count_t                 lc;
  logic [CW-1:0]          fcount, hcount, idx, j, n, outn;
  logic                   stale, pass;
  logic [2*LINE_BITS-1:0] fse_q, hq;
  logic                   col_q;
  line_t                  ins_s, ins_e, ms, me;

  qctl_t                  qctl;
  logic                   q_vis;
  line_t                  q_vrow, q_mline;
  count_t                 q_vcount;

  line_t                  fs, fe, hs, he;
  logic [CW-1:0]          idx_inc;

  always_comb begin
    fs      = fse_q[2*LINE_BITS-1:LINE_BITS];
    fe      = fse_q[LINE_BITS-1:0];
    hs      = hq[2*LINE_BITS-1:LINE_BITS];
    he      = hq[LINE_BITS-1:0];
    idx_inc = idx + 1'b1;
    qctl.init = (state == S_Q_INIT);
    qctl.step = (state == S_Q_USE);
  end

  assign busy = (state != S_IDLE);

  frvm_query u_query (
    .clk    (clk),
    .ctl    (qctl),
    .ln     (cq.line),
    .row    (cq.row_index),
    .lc     (lc),
    .span_s (hs),
    .span_e (he),
    .vis    (q_vis),
    .vrow   (q_vrow),
    .mline  (q_mline),
    .vcount (q_vcount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      fcount <= '0;
      hcount <= '0;
      stale  <= 1'b0;
      lc     <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) lc <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cq     <= cmd;
            result <= '0;
            idx    <= '0;
            pass   <= 1'b0;
            n      <= '0;
            unique case (cmd.action)
              ACT_CLEAR: begin
                fcount <= '0;
                hcount <= '0;
                stale  <= 1'b0;
                done   <= 1'b1;
              end
              ACT_APPEND: begin
                done <= 1'b1;
                if (cmd.range_end <= cmd.range_start) begin
                  result.status <= ST_INVALID;
                end else if (fcount >= MAXC) begin
                  result.status <= ST_FULL;
                end else begin
                  fold_se[fcount[AW-1:0]]  <= {cmd.range_start, cmd.range_end};
                  fold_col[fcount[AW-1:0]] <= cmd.start_collapsed;
                  fcount <= fcount + 1'b1;
                  stale  <= 1'b1;
                end
              end
              ACT_TOGGLE: begin
                if (fcount == '0) begin
                  result.status <= ST_NO_RANGE;
                  done <= 1'b1;
                end else begin
                  state <= S_TG_RD;
                end
              end
              ACT_FOLD, ACT_UNFOLD: begin
                stale <= 1'b1;
                if (fcount == '0) done <= 1'b1;
                else state <= S_SWEEP;
              end
              ACT_MAP_LN, ACT_MAP_ROW: begin
                state <= stale ? S_RB_RD : S_Q_INIT;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SWEEP: begin
          fold_col[idx[AW-1:0]] <= (cq.action == ACT_FOLD);
          idx <= idx_inc;
          if (idx_inc == fcount) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_TG_RD: begin
          fse_q <= fold_se[idx[AW-1:0]];
          state <= S_TG_CMP;
        end
        S_TG_CMP: begin
          if (pass ? (cq.line > fs && cq.line <= fe) : (cq.line == fs)) begin
            state <= S_FL_RD;
          end else if (idx_inc == fcount) begin
            if (pass) begin
              result.status <= ST_NO_RANGE;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              pass  <= 1'b1;
              idx   <= '0;
              state <= S_TG_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_TG_RD;
          end
        end
        S_FL_RD: begin
          col_q <= fold_col[idx[AW-1:0]];
          state <= S_FL_WR;
        end
        S_FL_WR: begin
          fold_col[idx[AW-1:0]] <= ~col_q;
          stale <= 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RB_RD: begin
          if (idx == fcount) begin
            idx  <= '0;
            outn <= '0;
            if (n == '0) begin
              hcount <= '0;
              stale  <= 1'b0;
              state  <= S_Q_INIT;
            end else begin
              state <= S_MG_RD;
            end
          end else begin
            fse_q <= fold_se[idx[AW-1:0]];
            col_q <= fold_col[idx[AW-1:0]];
            state <= S_RB_CHK;
          end
        end
        S_RB_CHK: begin
          ins_s <= fs + 1'b1;
          ins_e <= fe;
          if (!col_q) begin
            idx   <= idx_inc;
            state <= S_RB_RD;
          end else if (n == '0) begin
            hid[0] <= {fs + 1'b1, fe};
            n      <= CW'(1);
            idx    <= idx_inc;
            state  <= S_RB_RD;
          end else begin
            j     <= n;
            hq    <= hid[AW'(n - 1'b1)];
            state <= S_RB_CMP;
          end
        end
        S_RB_CMP: begin
          if (hs > ins_s || (hs == ins_s && he > ins_e)) begin
            hid[j[AW-1:0]] <= hq;
            j <= j - 1'b1;
            if (j == 1) state <= S_RB_INS;
            else hq <= hid[AW'(j - 2'd2)];
          end else begin
            hid[j[AW-1:0]] <= {ins_s, ins_e};
            n     <= n + 1'b1;
            idx   <= idx_inc;
            state <= S_RB_RD;
          end
        end
        S_RB_INS: begin
          hid[j[AW-1:0]] <= {ins_s, ins_e};
          n     <= n + 1'b1;
          idx   <= idx_inc;
          state <= S_RB_RD;
        end
        S_MG_RD: begin
          hq    <= hid[idx[AW-1:0]];
          state <= S_MG_USE;
        end
        S_MG_USE: begin
          if (outn != '0 && {1'b0, hs} <= {1'b0, me} + 1'b1) begin
            if (he > me) me <= he;
          end else begin
            if (outn != '0) hid[AW'(outn - 1'b1)] <= {ms, me};
            ms   <= hs;
            me   <= he;
            outn <= outn + 1'b1;
          end
          if (idx_inc == n) begin
            state <= S_MG_FLUSH;
          end else begin
            idx   <= idx_inc;
            state <= S_MG_RD;
          end
        end
        S_MG_FLUSH: begin
          hid[AW'(outn - 1'b1)] <= {ms, me};
          hcount <= outn;
          stale  <= 1'b0;
          state  <= S_Q_INIT;
        end
        S_Q_INIT: begin
          idx   <= '0;
          state <= (hcount == '0) ? S_Q_END : S_Q_RD;
        end
        S_Q_RD: begin
          hq    <= hid[idx[AW-1:0]];
          state <= S_Q_USE;
        end
        S_Q_USE: begin
          idx   <= idx_inc;
          state <= (idx_inc == hcount) ? S_Q_END : S_Q_RD;
        end
        S_Q_END: begin
          result.visible_count <= q_vcount;
          if (cq.action == ACT_MAP_LN) begin
            result.visible     <= q_vis;
            result.visible_row <= q_vrow;
          end else begin
            result.mapped_line <= q_mline;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_fold_range_visibility_map_top.sv -----
// ----------------------------------------------------------------------------
// tb_fold_range_visibility_map_top
// Self-checking bench for the fold range visibility map. A local fold table
// model predicts each result. Directed edge cases come first, then a table
// fill past capacity. Random phases of all command kinds follow, each at the
// line count set for it, with random sender idle bursts unless quiet is set.
// ----------------------------------------------------------------------------
module tb_fold_range_visibility_map_top;
  import frvm_pkg::*;

  localparam int NMAX     = MAX_RANGES_DEF;
  localparam int WD_LIMIT = 400000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  cmd_t   cmd = '0;
  logic   done;
  res_t   result;
  logic   cfg_we = 1'b0;
  count_t cfg_data = '0;

  fold_range_visibility_map_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // fold table model
  line_t  fs [NMAX];
  line_t  fe [NMAX];
  bit     fc [NMAX];
  int     fn;
  line_t  hs [NMAX];
  line_t  he [NMAX];
  int     hn;
  bit     stale;
  count_t doc_lines;

  res_t   pending_res [$];
  int     errors, n_items, n_results, wd;
  bit     quiet;

  function automatic void merge_spans();
    int n, outn, j;
    line_t s, e;
    n = 0;
    outn = 0;
    if (!stale) return;
    for (int i = 0; i < fn; i++) begin
      if (fc[i]) begin
        s = fs[i] + 1'b1;
        e = fe[i];
        if (e >= s) begin
          j = n;
          while (j > 0 && (hs[j-1] > s || (hs[j-1] == s && he[j-1] > e))) begin
            hs[j] = hs[j-1];
            he[j] = he[j-1];
            j--;
          end
          hs[j] = s;
          he[j] = e;
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (outn > 0 && longint'(hs[i]) <= longint'(he[outn-1]) + 1) begin
        if (he[i] > he[outn-1]) he[outn-1] = he[i];
      end else begin
        hs[outn] = hs[i];
        he[outn] = he[i];
        outn++;
      end
    end
    hn = outn;
    stale = 0;
  endfunction

  function automatic count_t visible_lines();
    longint hid, lc, s, e;
    hid = 0;
    lc = doc_lines;
    for (int i = 0; i < hn; i++) begin
      s = hs[i];
      e = he[i];
      if (s >= lc) break;
      if (e >= lc) e = lc - 1;
      if (e >= s) hid += e - s + 1;
    end
    return (lc > hid) ? count_t'(lc - hid) : '0;
  endfunction

  function automatic logic line_shown(line_t ln);
    for (int i = 0; i < hn; i++)
      if (ln >= hs[i] && ln <= he[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic line_t row_of_line(line_t ln);
    longint hid;
    hid = 0;
    for (int i = 0; i < hn; i++) begin
      if (hs[i] >= ln) break;
      if (he[i] < ln) hid += longint'(he[i]) - hs[i] + 1;
      else begin
        hid += longint'(ln) - hs[i];
        break;
      end
    end
    return (longint'(ln) > hid) ? line_t'(longint'(ln) - hid) : '0;
  endfunction

  function automatic line_t line_of_row(line_t row);
    longint lc, cur, rem, s, e, span, r;
    lc = doc_lines;
    cur = 0;
    rem = row;
    if (lc == 0) return '0;
    for (int i = 0; i < hn; i++) begin
      s = hs[i];
      e = he[i];
      if (e < cur) continue;
      if (s >= lc) break;
      span = (s > cur) ? s - cur : 0;
      if (rem < span) return (cur + rem > 64'hFFFFF) ? '1 : line_t'(cur + rem);
      rem -= span;
      cur = e + 1;
      if (cur > lc) begin
        cur = lc;
        break;
      end
    end
    r = cur + rem;
    if (r >= lc) r = lc - 1;
    if (r > 64'hFFFFF) r = 64'hFFFFF;
    return line_t'(r);
  endfunction

  function automatic res_t fold_step(cmd_t c);
    res_t r;
    int hit;
    r = '0;
    case (c.action)
      ACT_CLEAR: begin
        fn = 0;
        hn = 0;
        stale = 0;
      end
      ACT_APPEND: begin
        if (c.range_end <= c.range_start) r.status = ST_INVALID;
        else if (fn >= NMAX) r.status = ST_FULL;
        else begin
          fs[fn] = c.range_start;
          fe[fn] = c.range_end;
          fc[fn] = c.start_collapsed;
          fn++;
          stale = 1;
        end
      end
      ACT_TOGGLE: begin
        hit = -1;
        for (int i = 0; i < fn; i++)
          if (fs[i] == c.line) begin
            hit = i;
            break;
          end
        if (hit < 0)
          for (int i = 0; i < fn; i++)
            if (c.line > fs[i] && c.line <= fe[i]) begin
              hit = i;
              break;
            end
        if (hit < 0) r.status = ST_NO_RANGE;
        else begin
          fc[hit] = ~fc[hit];
          stale = 1;
        end
      end
      ACT_FOLD, ACT_UNFOLD: begin
        for (int i = 0; i < fn; i++) fc[i] = (c.action == ACT_FOLD);
        stale = 1;
      end
      ACT_MAP_LN: begin
        merge_spans();
        r.visible = line_shown(c.line);
        r.visible_row = row_of_line(c.line);
        r.visible_count = visible_lines();
      end
      ACT_MAP_ROW: begin
        merge_spans();
        r.mapped_line = line_of_row(c.row_index);
        r.visible_count = visible_lines();
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_results);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_res.size() == 0) report("unexpected transfer", 1, 0);
      else begin
        res_t w;
        w = pending_res.pop_front();
        if (result.status !== w.status) report("status", result.status, w.status);
        if (result.visible !== w.visible) report("visible", result.visible, w.visible);
        if (result.visible_row !== w.visible_row)
          report("visible_row", result.visible_row, w.visible_row);
        if (result.mapped_line !== w.mapped_line)
          report("mapped_line", result.mapped_line, w.mapped_line);
        if (result.visible_count !== w.visible_count)
          report("visible_count", result.visible_count, w.visible_count);
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", wd);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(cmd_t c);
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_res.push_back(fold_step(c));
    n_items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_lines(count_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    doc_lines = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_t mk(logic [2:0] a, line_t ln, line_t row, line_t rs, line_t re,
                              logic sc);
    cmd_t c;
    c.action = a;
    c.line = ln;
    c.row_index = row;
    c.range_start = rs;
    c.range_end = re;
    c.start_collapsed = sc;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int span);
    cmd_t c;
    int k;
    line_t b;
    c = cmd_t'({$urandom, $urandom, $urandom});
    b = line_t'($urandom_range(0, span));
    k = $urandom_range(0, 99);
    if (k < 28) begin
      c.action = ACT_APPEND;
      c.range_start = b;
      c.range_end = b + line_t'($urandom_range(1, 40));
      if ($urandom_range(0, 15) == 0) c.range_end = b - line_t'($urandom_range(0, 3));
    end else if (k < 43) begin
      c.action = ACT_TOGGLE;
      c.line = (fn > 0 && $urandom_range(0, 1)) ? fs[$urandom_range(0, fn - 1)] : b;
    end else if (k < 47) c.action = ACT_FOLD;
    else if (k < 51) c.action = ACT_UNFOLD;
    else if (k < 75) begin
      c.action = ACT_MAP_LN;
      c.line = $urandom_range(0, 7) == 0 ? c.line : b;
    end else if (k < 98) begin
      c.action = ACT_MAP_ROW;
      c.row_index = $urandom_range(0, 7) == 0 ? c.row_index : b;
    end else if (k < 99) c.action = ACT_CLEAR;
    else c.action = 3'd7;
    if (fn > 24 && c.action == ACT_APPEND) c.action = ACT_CLEAR;
    return c;
  endfunction

  task automatic test_directed_edges();
    set_lines('0);
    send(mk(ACT_MAP_ROW, '0, 20'd5, '0, '0, 0));
    send(mk(ACT_MAP_LN, '1, '0, '0, '0, 0));
    send(mk(ACT_APPEND, '0, '0, 20'd10, 20'd10, 1));
    send(mk(ACT_APPEND, '0, '0, 20'd11, 20'd3, 1));
    send(mk(ACT_APPEND, '0, '0, 20'd10, 20'd20, 1));
    send(mk(ACT_APPEND, '0, '0, 20'd21, 20'd30, 1));
    send(mk(ACT_APPEND, '0, '0, 20'd15, 20'd18, 0));
    send(mk(ACT_APPEND, '0, '0, '0, '1, 0));
    set_lines(count_t'(50));
    send(mk(ACT_MAP_LN, 20'd25, '0, '0, '0, 0));
    send(mk(ACT_MAP_ROW, '0, 20'd12, '0, '0, 0));
    send(mk(ACT_MAP_ROW, '0, '1, '0, '0, 0));
    send(mk(ACT_TOGGLE, 20'd15, '0, '0, '0, 0));
    send(mk(ACT_TOGGLE, 20'd25, '0, '0, '0, 0));
    send(mk(ACT_TOGGLE, 20'd10, '0, '0, '0, 0));
    send(mk(ACT_MAP_LN, 20'd16, '0, '0, '0, 0));
    send(mk(ACT_FOLD, '0, '0, '0, '0, 0));
    send(mk(ACT_MAP_LN, 20'd40, '0, '0, '0, 0));
    set_lines(count_t'(21'h100000));
    send(mk(ACT_MAP_ROW, '0, '1, '0, '0, 0));
    send(mk(ACT_MAP_LN, '1, '0, '0, '0, 0));
    send(mk(ACT_UNFOLD, '0, '0, '0, '0, 0));
    send(mk(ACT_TOGGLE, 20'd5000, '0, '0, '0, 0));
    send(mk(3'd7, '1, '1, '1, '1, 1));
    send(mk(ACT_MAP_ROW, '0, '1, '0, '0, 0));
    send(mk(ACT_CLEAR, '0, '0, '0, '0, 0));
    send(mk(ACT_MAP_LN, 20'd7, '0, '0, '0, 0));
    drain();
  endtask

  task automatic test_table_full();
    set_lines(count_t'(4000));
    for (int i = 0; i < NMAX; i++)
      send(mk(ACT_APPEND, '0, '0, line_t'(i * 9), line_t'(i * 9 + 4), logic'(i[0])));
    send(mk(ACT_APPEND, '0, '0, 20'd1, 20'd2, 1));
    send(mk(ACT_APPEND, '0, '0, 20'd2, 20'd2, 1));
    send(mk(ACT_MAP_ROW, '0, 20'd1000, '0, '0, 0));
    send(mk(ACT_TOGGLE, 20'd2298, '0, '0, '0, 0));
    send(mk(ACT_MAP_LN, 20'd2000, '0, '0, '0, 0));
    send(mk(ACT_CLEAR, '0, '0, '0, '0, 0));
    drain();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    count_t lc;
    for (int p = 0; p < phases; p++) begin
      case (p % 5)
        0: lc = count_t'($urandom_range(0, 3));
        1: lc = count_t'($urandom_range(50, 400));
        2: lc = count_t'(21'h100000);
        3: lc = count_t'($urandom_range(0, 21'h1FFFFF));
        default: lc = count_t'($urandom_range(100, 1000));
      endcase
      set_lines(lc);
      for (int i = 0; i < per_phase; i++)
        send(rand_cmd(lc > 1200 ? 1200 : int'(lc) + 20));
      drain();
    end
  endtask

  initial begin
    errors = 0;
    n_items = 0;
    n_results = 0;
    quiet = 0;
    fn = 0;
    hn = 0;
    stale = 0;
    doc_lines = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_table_full();
    test_random_phases(10, 75);
    quiet = 1;
    test_random_phases(2, 40);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d commands, %0d results, table fill past capacity", n_items, n_results);
    $display("line counts from zero to the maximum, %0d mismatches", errors);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/frvm_pkg.sv
sv/frvm_query.sv
sv/fold_range_visibility_map_top.sv
tb/tb_fold_range_visibility_map_top.sv
